### rtl/histeq_pkg.sv
`timescale 1ns / 1ps
// histeq_pkg: shared constants, opcode codes, divider request and response types
// for the histogram equalizer. No dependencies.
package histeq_pkg;

    localparam int unsigned MAX_PIXELS = 4194304;
    localparam int unsigned PIX_W      = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SAMP_W     = $clog2(3 * MAX_PIXELS + 1);

    localparam int unsigned LEVELS     = 256;
    localparam int unsigned LVL_W      = $clog2(LEVELS);
    localparam int unsigned MAP_SCALE  = 2 * (LEVELS - 1);

    localparam longint unsigned MAX_NUM = 64'(3) * 64'(MAX_PIXELS) * 64'(MAP_SCALE + 1);
    localparam int unsigned NUM_W      = $clog2(MAX_NUM + 1);
    localparam int unsigned DEN_W      = SAMP_W + 1;
    localparam int unsigned QUO_W      = LVL_W;
    localparam int unsigned SH_W       = DEN_W + QUO_W - 1;
    localparam int unsigned CMP_W      = (NUM_W > SH_W) ? NUM_W : SH_W;
    localparam int unsigned CNT_W      = $clog2(QUO_W);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_COUNT = 2'd1,
        OP_BUILD = 2'd2,
        OP_MAP   = 2'd3
    } op_t;

    typedef struct packed {
        logic             load;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } div_rsp_t;

endpackage

### rtl/histeq_ram.sv
`timescale 1ns / 1ps
// histeq_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
module histeq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/histeq_div.sv
`timescale 1ns / 1ps
// histeq_div: restoring divider, one quotient bit per cycle.
// Depends on histeq_pkg.
module histeq_div (
    input  logic                clk,
    input  logic                rst_n,
    input  histeq_pkg::div_req_t req,
    output histeq_pkg::div_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [histeq_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [histeq_pkg::NUM_W-1:0]        rem_reg, rem_next;
    logic [histeq_pkg::SH_W-1:0]         den_sh_reg, den_sh_next;
    logic [histeq_pkg::QUO_W-1:0]        quo_reg, quo_next;
    logic                                ge;

    assign ge = histeq_pkg::CMP_W'(rem_reg) >= histeq_pkg::CMP_W'(den_sh_reg);

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        den_sh_next = den_sh_reg;
        quo_next    = quo_reg;
        if (req.load)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            rem_next    = req.num;
            den_sh_next = histeq_pkg::SH_W'(req.den) << (histeq_pkg::QUO_W - 1);
            quo_next    = '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = histeq_pkg::NUM_W'(histeq_pkg::CMP_W'(rem_reg)
                                              - histeq_pkg::CMP_W'(den_sh_reg));
            end
            quo_next    = {quo_reg[histeq_pkg::QUO_W-2:0], ge};
            den_sh_next = den_sh_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == histeq_pkg::CNT_W'(histeq_pkg::QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        den_sh_reg <= den_sh_next;
        quo_reg    <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### rtl/histogram_equalizer_core.sv
`timescale 1ns / 1ps
// histogram_equalizer_core: top level, sequencer over bin RAM, map RAM and divider.
// Depends on histeq_pkg, histeq_ram, histeq_div.
//
//  channel   signals                                         handshake
//  request   opcode, sample_first/second/third               start & !busy
//  result    mapped_first/second/third                       done, one cycle
//  config    cfg_data (color_mode)                           cfg_we
//
// Clear: one bin per cycle. Count: a bin read and a bin write per sample, one
// sample in gray mode, three in color; a count past the pixel limit is dropped.
// Build, per level: bin read, accumulate, load, 8 divider steps plus done, map
// write. Map: one sample at a time, set by the single read port of the map RAM.
// After reset a sweep zeroes both RAMs with busy high.
// The receiver cannot stall; done rises together with the registered result.
module histogram_equalizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] sample_first,
    input  logic [7:0] sample_second,
    input  logic [7:0] sample_third,
    output logic       done,
    output logic [7:0] mapped_first,
    output logic [7:0] mapped_second,
    output logic [7:0] mapped_third,
    input  logic       cfg_we,
    input  logic       cfg_data
);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_CLR  = 13'b0000000000010,
        S_CRD  = 13'b0000000000100,
        S_CWR  = 13'b0000000001000,
        S_BRD  = 13'b0000000010000,
        S_BACC = 13'b0000000100000,
        S_BNUM = 13'b0000001000000,
        S_BDIV = 13'b0000010000000,
        S_BWR  = 13'b0000100000000,
        S_M0   = 13'b0001000000000,
        S_M1   = 13'b0010000000000,
        S_M2   = 13'b0100000000000,
        S_M3   = 13'b1000000000000
    } state_t;

    localparam int unsigned LVL_W  = histeq_pkg::LVL_W;
    localparam int unsigned SAMP_W = histeq_pkg::SAMP_W;
    localparam int unsigned PIX_W  = histeq_pkg::PIX_W;

    state_t                state_reg, state_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  clr_map_reg, clr_map_next;
    logic                  color_mode_reg, color_mode_next;
    logic [SAMP_W-1:0]     samp_total_reg, samp_total_next;
    logic [PIX_W-1:0]      pix_total_reg, pix_total_next;
    logic                  done_reg, done_next;
    logic [SAMP_W-1:0]     acc_reg, acc_next;
    logic [LVL_W-1:0]      smp_reg [3];
    logic [LVL_W-1:0]      smp_next [3];
    logic [7:0]            map0_reg, map0_next;
    logic [7:0]            map1_reg, map1_next;
    logic [7:0]            map2_reg, map2_next;

    logic                  bin_we;
    logic [LVL_W-1:0]      bin_waddr, bin_raddr;
    logic [SAMP_W-1:0]     bin_wdata, bin_rdata;
    logic                  map_we;
    logic [LVL_W-1:0]      map_waddr, map_raddr;
    logic [7:0]            map_wdata, map_rdata;

    histeq_pkg::div_req_t  div_req;
    histeq_pkg::div_rsp_t  div_rsp;
    histeq_pkg::op_t       op;
    logic                  accept;
    logic [LVL_W-1:0]      cur_smp;

    assign op      = histeq_pkg::op_t'(opcode);
    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign cur_smp = smp_reg[idx_reg];

    histeq_ram #(.WIDTH(SAMP_W), .DEPTH(histeq_pkg::LEVELS)) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    histeq_ram #(.WIDTH(8), .DEPTH(histeq_pkg::LEVELS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign div_req.load = (state_reg == S_BNUM);
    assign div_req.num  = histeq_pkg::NUM_W'(acc_reg) * histeq_pkg::NUM_W'(histeq_pkg::MAP_SCALE)
                          + histeq_pkg::NUM_W'(samp_total_reg);
    assign div_req.den  = {samp_total_reg, 1'b0};

    histeq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        lvl_next        = lvl_reg;
        idx_next        = idx_reg;
        clr_map_next    = clr_map_reg;
        color_mode_next = cfg_we ? cfg_data : color_mode_reg;
        samp_total_next = samp_total_reg;
        pix_total_next  = pix_total_reg;
        done_next       = 1'b0;
        acc_next        = acc_reg;
        smp_next        = smp_reg;
        map0_next       = map0_reg;
        map1_next       = map1_reg;
        map2_next       = map2_reg;

        bin_we    = 1'b0;
        bin_waddr = lvl_reg;
        bin_wdata = '0;
        bin_raddr = lvl_reg;
        map_we    = 1'b0;
        map_waddr = lvl_reg;
        map_wdata = '0;
        map_raddr = cur_smp;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    smp_next[0] = sample_first;
                    smp_next[1] = sample_second;
                    smp_next[2] = sample_third;
                    idx_next    = '0;
                    lvl_next    = '0;
                    unique case (op)
                        histeq_pkg::OP_CLEAR:
                        begin
                            samp_total_next = '0;
                            pix_total_next  = '0;
                            state_next      = S_CLR;
                        end
                        histeq_pkg::OP_COUNT:
                        begin
                            if (pix_total_reg < PIX_W'(histeq_pkg::MAX_PIXELS))
                            begin
                                pix_total_next  = pix_total_reg + 1'b1;
                                samp_total_next = samp_total_reg
                                                  + (color_mode_reg ? SAMP_W'(3) : SAMP_W'(1));
                                state_next      = S_CRD;
                            end
                        end
                        histeq_pkg::OP_BUILD:
                        begin
                            acc_next   = '0;
                            state_next = S_BRD;
                        end
                        histeq_pkg::OP_MAP:
                        begin
                            state_next = S_M0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                bin_we   = 1'b1;
                map_we   = clr_map_reg;
                lvl_next = lvl_reg + 1'b1;
                if (lvl_reg == '1)
                begin
                    clr_map_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_CRD:
            begin
                bin_raddr  = cur_smp;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                bin_we    = 1'b1;
                bin_waddr = cur_smp;
                bin_wdata = bin_rdata + 1'b1;
                if (color_mode_reg && (idx_reg != 2'd2))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_BRD:
            begin
                state_next = S_BACC;
            end
            S_BACC:
            begin
                acc_next   = acc_reg + bin_rdata;
                state_next = S_BNUM;
            end
            S_BNUM:
            begin
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_BWR;
                end
            end
            S_BWR:
            begin
                map_we    = 1'b1;
                map_wdata = (samp_total_reg == '0) ? 8'd0 : div_rsp.quo;
                lvl_next  = lvl_reg + 1'b1;
                state_next = (lvl_reg == '1) ? S_IDLE : S_BRD;
            end
            S_M0:
            begin
                map_raddr  = smp_reg[0];
                state_next = S_M1;
            end
            S_M1:
            begin
                map_raddr = smp_reg[1];
                map0_next = map_rdata;
                if (color_mode_reg)
                begin
                    state_next = S_M2;
                end
                else
                begin
                    map1_next  = 8'd0;
                    map2_next  = 8'd0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_M2:
            begin
                map_raddr  = smp_reg[2];
                map1_next  = map_rdata;
                state_next = S_M3;
            end
            S_M3:
            begin
                map2_next  = map_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            lvl_reg        <= '0;
            idx_reg        <= '0;
            clr_map_reg    <= 1'b1;
            color_mode_reg <= 1'b0;
            samp_total_reg <= '0;
            pix_total_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lvl_reg        <= lvl_next;
            idx_reg        <= idx_next;
            clr_map_reg    <= clr_map_next;
            color_mode_reg <= color_mode_next;
            samp_total_reg <= samp_total_next;
            pix_total_reg  <= pix_total_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        smp_reg  <= smp_next;
        map0_reg <= map0_next;
        map1_reg <= map1_next;
        map2_reg <= map2_next;
    end

    assign done          = done_reg;
    assign mapped_first  = map0_reg;
    assign mapped_second = map1_reg;
    assign mapped_third  = map2_reg;

endmodule

### rtl/histeq_checker.sv
`timescale 1ns / 1ps
// histeq_checker: port-level checks for histogram_equalizer_core, with bind.
// Depends on histeq_pkg.
module histeq_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] opcode,
    input logic       done,
    input logic [7:0] mapped_second,
    input logic [7:0] mapped_third,
    input logic       cfg_we,
    input logic       cfg_data
);

    logic mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    // an accepted map request must raise busy
    a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == histeq_pkg::OP_MAP) |=> busy)
        else $error("map request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result without preceding work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !mode_reg) |-> (mapped_second == 8'd0 && mapped_third == 8'd0))
        else $error("gray result with nonzero second or third field");

endmodule

bind histogram_equalizer_core histeq_checker u_histeq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .done          (done),
    .mapped_second (mapped_second),
    .mapped_third  (mapped_third),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data)
);

### dv/histogram_equalizer_core_tb.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for histogram_equalizer_core, gray and color modes.
// Predicts bins, totals and map table internally. Depends on histeq_pkg and the core RTL.
module testbench;

    localparam int unsigned DRAIN_CYCLES  = 3100;
    localparam int unsigned SETTLE_LIMIT  = 20000;
    localparam longint unsigned LIMIT_CYCLES = 10000000;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } mapped_pixel_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    histeq_pkg::op_t opcode = histeq_pkg::OP_CLEAR;
    logic [7:0]      sample_first = 8'd0;
    logic [7:0]      sample_second = 8'd0;
    logic [7:0]      sample_third = 8'd0;
    logic            done;
    logic [7:0]      mapped_first;
    logic [7:0]      mapped_second;
    logic [7:0]      mapped_third;
    logic            cfg_we = 1'b0;
    logic            cfg_data = 1'b0;

    int unsigned     hist_bins [histeq_pkg::LEVELS];
    int unsigned     hist_samples;
    int unsigned     hist_pixels;
    logic [7:0]      eq_lut [histeq_pkg::LEVELS];
    logic            mode_color;
    mapped_pixel_t   pending_pixels [$];

    int              fail_count;
    int              requests_sent;
    int              sender_idle_pct;
    longint unsigned cycle_count;

    histogram_equalizer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .sample_first  (sample_first),
        .sample_second (sample_second),
        .sample_third  (sample_third),
        .done          (done),
        .mapped_first  (mapped_first),
        .mapped_second (mapped_second),
        .mapped_third  (mapped_third),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        mapped_pixel_t exp_px;
        if (rst_n && done)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result: %0d %0d %0d",
                       mapped_first, mapped_second, mapped_third);
                fail_count++;
            end
            else
            begin
                exp_px = pending_pixels.pop_front();
                if (mapped_first !== exp_px.first)
                begin
                    $error("mapped_first expected %0d got %0d", exp_px.first, mapped_first);
                    fail_count++;
                end
                if (mapped_second !== exp_px.second)
                begin
                    $error("mapped_second expected %0d got %0d", exp_px.second, mapped_second);
                    fail_count++;
                end
                if (mapped_third !== exp_px.third)
                begin
                    $error("mapped_third expected %0d got %0d", exp_px.third, mapped_third);
                    fail_count++;
                end
            end
        end
    end

    task automatic clear_histogram();
        for (int i = 0; i < histeq_pkg::LEVELS; i++)
            hist_bins[i] = 0;
        hist_samples = 0;
        hist_pixels = 0;
    endtask

    task automatic build_lut();
        longint unsigned acc;
        longint unsigned den;
        longint unsigned q;
        acc = 0;
        den = 64'(hist_samples) * 2;
        for (int lvl = 0; lvl < histeq_pkg::LEVELS; lvl++)
        begin
            acc += hist_bins[lvl];
            if (hist_samples == 0)
                eq_lut[lvl] = 8'd0;
            else
            begin
                q = (acc * 510 + 64'(hist_samples)) / den;
                if (q > 255)
                    q = 255;
                eq_lut[lvl] = q[7:0];
            end
        end
    endtask

    task automatic predict_request(input histeq_pkg::op_t op, input logic [7:0] a,
                                   input logic [7:0] b, input logic [7:0] c);
        mapped_pixel_t px;
        case (op)
            histeq_pkg::OP_CLEAR: clear_histogram();
            histeq_pkg::OP_COUNT:
            begin
                if (hist_pixels < histeq_pkg::MAX_PIXELS)
                begin
                    hist_pixels++;
                    hist_bins[a]++;
                    hist_samples++;
                    if (mode_color)
                    begin
                        hist_bins[b]++;
                        hist_bins[c]++;
                        hist_samples += 2;
                    end
                end
            end
            histeq_pkg::OP_BUILD: build_lut();
            default:
            begin
                px.first  = eq_lut[a];
                px.second = mode_color ? eq_lut[b] : 8'd0;
                px.third  = mode_color ? eq_lut[c] : 8'd0;
                pending_pixels.push_back(px);
            end
        endcase
    endtask

    task automatic send_request(input histeq_pkg::op_t op, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        opcode        <= op;
        sample_first  <= a;
        sample_second <= b;
        sample_third  <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(op, a, b, c);
        requests_sent++;
    endtask

    task automatic settle_block();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_pixels.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_color_mode(input logic value);
        settle_block();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_color = value;
    endtask

    function automatic logic [7:0] pick_sample(input int lo, input int hi);
        if ($urandom_range(99) < 15)
            return $urandom_range(1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(hi, lo));
    endfunction

    task automatic test_reset_state();
        send_request(histeq_pkg::OP_MAP, 8'd0, 8'd255, 8'd0);
        write_color_mode(1'b1);
        send_request(histeq_pkg::OP_MAP, 8'd255, 8'd0, 8'd128);
    endtask

    task automatic test_empty_build();
        send_request(histeq_pkg::OP_BUILD, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_MAP, 8'd0, 8'd128, 8'd255);
    endtask

    task automatic test_gray_levels();
        write_color_mode(1'b0);
        send_request(histeq_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_COUNT, 8'd0, 8'd255, 8'd255);
        send_request(histeq_pkg::OP_COUNT, 8'd255, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_COUNT, 8'd255, 8'd255, 8'd255);
        send_request(histeq_pkg::OP_COUNT, 8'd128, 8'd1, 8'd2);
        send_request(histeq_pkg::OP_BUILD, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_MAP, 8'd0, 8'd255, 8'd255);
        send_request(histeq_pkg::OP_MAP, 8'd128, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_MAP, 8'd255, 8'd128, 8'd7);
        send_request(histeq_pkg::OP_MAP, 8'd127, 8'd200, 8'd99);
    endtask

    task automatic test_color_levels();
        write_color_mode(1'b1);
        send_request(histeq_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_COUNT, 8'd0, 8'd255, 8'd170);
        send_request(histeq_pkg::OP_COUNT, 8'd255, 8'd85, 8'd0);
        send_request(histeq_pkg::OP_BUILD, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_MAP, 8'd0, 8'd85, 8'd255);
        // map table survives a clear
        send_request(histeq_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_MAP, 8'd170, 8'd255, 8'd1);
    endtask

    task automatic test_mode_switch_count();
        send_request(histeq_pkg::OP_CLEAR, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_COUNT, 8'd10, 8'd20, 8'd30);
        write_color_mode(1'b0);
        send_request(histeq_pkg::OP_COUNT, 8'd200, 8'd5, 8'd6);
        send_request(histeq_pkg::OP_BUILD, 8'd0, 8'd0, 8'd0);
        send_request(histeq_pkg::OP_MAP, 8'd10, 8'd20, 8'd200);
    endtask

    task automatic run_sequence();
        int lo;
        int hi;
        int n_count;
        int n_map;
        lo = $urandom_range(255);
        hi = $urandom_range(255, lo);
        if ($urandom_range(99) < 40)
        begin
            lo = 0;
            hi = 255;
        end
        if ($urandom_range(99) < 80)
            send_request(histeq_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
        n_count = $urandom_range(40, 1);
        n_map = $urandom_range(12, 2);
        repeat (n_count)
            send_request(histeq_pkg::OP_COUNT, pick_sample(lo, hi), pick_sample(lo, hi),
                         pick_sample(lo, hi));
        send_request(histeq_pkg::OP_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (n_map)
            send_request(histeq_pkg::OP_MAP, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic run_noise();
        repeat ($urandom_range(6, 1))
            send_request(histeq_pkg::op_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endtask

    task automatic test_random_traffic(input int n_items);
        logic phase_mode [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        int   phase_idle [3] = '{6, 70, 0};
        int   target;
        target = requests_sent;
        for (int p = 0; p < 6; p++)
        begin
            sender_idle_pct = phase_idle[p / 2];
            write_color_mode(phase_mode[p]);
            target += n_items / 6;
            while (requests_sent < target)
            begin
                if ($urandom_range(99) < 85)
                    run_sequence();
                else
                    run_noise();
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        requests_sent = 0;
        sender_idle_pct = 0;
        cycle_count = 0;
        mode_color = 1'b0;
        clear_histogram();
        for (int i = 0; i < histeq_pkg::LEVELS; i++)
            eq_lut[i] = 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_empty_build();
        test_gray_levels();
        test_color_levels();
        test_mode_switch_count();
        test_random_traffic(850);

        settle_block();
        if (pending_pixels.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
